[src/urh_pkg.sv]
package urh_pkg;

    // Store geometry.
    localparam int HISTORY_DEPTH = 64;
    localparam int WORD_BITS     = 64;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Fixed field widths of the channels and the register.
    localparam int OPCODE_W      = 3;
    localparam int SNAP_W        = 64;
    localparam int SLOT_W        = 9;
    localparam int TIME_W        = 48;
    localparam int WINDOW_W      = 16;
    localparam int HELD_W        = 7;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd500;

    typedef logic [ADDR_W-1:0]    t_addr;
    typedef logic [CNT_W-1:0]     t_cnt;
    typedef logic [WORD_BITS-1:0] t_word;

    typedef enum logic [OPCODE_W-1:0] {
        OP_RESET  = 3'd0,
        OP_REBASE = 3'd1,
        OP_COMMIT = 3'd2,
        OP_UNDO   = 3'd3,
        OP_REDO   = 3'd4
    } t_opcode;

    // One access to the history store per word: a write or a read, never both.
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        t_addr addr;
        t_word wr_data;
    } t_mem_req;

    // Physical position of a logical index counted from the oldest entry.
    // Both operands are below HISTORY_DEPTH, so one subtract wraps the sum.
    function automatic t_addr slot_of(input t_addr base, input t_cnt idx);
        logic [CNT_W:0] sum;
        sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(idx);
        if (sum >= (CNT_W + 1)'(HISTORY_DEPTH)) begin
            sum = sum - (CNT_W + 1)'(HISTORY_DEPTH);
        end
        return ADDR_W'(sum);
    endfunction

endpackage

[src/urh_if.sv]
interface urh_in_if import urh_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [OPCODE_W-1:0]      opcode;
    logic [SNAP_W-1:0]        snapshot_word;
    logic                     is_weight_edit;
    logic signed [SLOT_W-1:0] edit_slot;
    logic [TIME_W-1:0]        time_ms;

    modport source (
        output valid, opcode, snapshot_word, is_weight_edit, edit_slot, time_ms,
        input  ready
    );
    modport sink (
        input  valid, opcode, snapshot_word, is_weight_edit, edit_slot, time_ms,
        output ready
    );
endinterface

interface urh_out_if import urh_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [SNAP_W-1:0] restored_word;
    logic              undo_possible;
    logic              redo_possible;
    logic [HELD_W-1:0] entries_held;

    modport source (
        output valid, status, restored_word, undo_possible, redo_possible, entries_held,
        input  ready
    );
    modport sink (
        input  valid, status, restored_word, undo_possible, redo_possible, entries_held,
        output ready
    );
endinterface

[src/undo_redo_history_ring.sv]
// Bounded undo/redo history ring. Every input word carries one operation
// (reset, rebase, commit, undo or redo) and yields exactly one result word
// with a status, the restored snapshot after a successful undo or redo, the
// undo/redo availability flags and the number of entries now held. The block
// takes one word per clock cycle when the result side keeps up; a result
// passes the first result stage, then the result register. The pointers are
// updated at the accepting edge and the single-port history store is written
// or read in that same cycle, so the store's one access per cycle sets the
// rate. The registered read data of the store forms the first result stage
// and a result register follows it, so one more word is accepted while a
// finished result waits to be taken. The coalescing window register may be
// written at any time the block is idle; it resets to 500 ms. The history
// starts empty and needs no clearing pass after reset: an entry is only ever
// read after it has been written.
module undo_redo_history_ring import urh_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [WINDOW_W-1:0] i_cfg_wr_data,
    urh_in_if.sink              i_in,
    urh_out_if.source           o_out
);

    // History pointers and coalescing state.
    t_addr                    r_oldest;
    t_cnt                     r_count;
    t_addr                    r_cursor;
    logic                     r_last_weight;
    logic signed [SLOT_W-1:0] r_last_slot;
    logic [TIME_W-1:0]        r_last_time;
    logic [WINDOW_W-1:0]      r_window;

    t_addr                    n_oldest;
    t_cnt                     n_count;
    t_addr                    n_cursor;
    logic                     n_last_weight;
    logic signed [SLOT_W-1:0] n_last_slot;
    logic [TIME_W-1:0]        n_last_time;

    // First result stage; its word comes from the store's read register.
    logic r_s_valid;
    logic r_s_status;
    logic r_s_restore;
    logic r_s_undo;
    logic r_s_redo;
    t_cnt r_s_count;

    // Result register.
    logic              r_o_valid;
    logic              r_o_status;
    logic [SNAP_W-1:0] r_o_word;
    logic              r_o_undo;
    logic              r_o_redo;
    logic [HELD_W-1:0] r_o_count;

    logic     in_ready;
    logic     accept;
    logic     s_move;
    t_opcode  op;
    t_word    word_in;
    t_mem_req mem_req;
    t_word    rd_data;

    logic              status;
    logic              restore;
    logic              coalesce;
    logic [TIME_W:0]   gap;
    logic              in_window;
    t_cnt              append_idx;

    // No word is taken while reset is held.
    assign s_move   = r_s_valid && (!r_o_valid || o_out.ready);
    assign in_ready = i_rst_n && (!r_s_valid || s_move);
    assign accept   = i_in.valid && in_ready;
    assign op       = t_opcode'(i_in.opcode);
    assign word_in  = WORD_BITS'(i_in.snapshot_word);

    // A time earlier than the last commit counts as inside the window.
    assign gap       = {1'b0, i_in.time_ms} - {1'b0, r_last_time};
    assign in_window = gap[TIME_W] || (gap[TIME_W-1:0] <= TIME_W'(r_window));
    assign coalesce  = i_in.is_weight_edit && r_last_weight && !i_in.edit_slot[SLOT_W-1]
                       && (i_in.edit_slot == r_last_slot) && in_window;

    always_comb begin
        n_oldest      = r_oldest;
        n_count       = r_count;
        n_cursor      = r_cursor;
        n_last_weight = r_last_weight;
        n_last_slot   = r_last_slot;
        n_last_time   = r_last_time;
        status        = 1'b0;
        restore       = 1'b0;
        append_idx    = t_cnt'(r_cursor) + t_cnt'(1);
        mem_req       = '{wr_en: 1'b0, rd_en: 1'b0,
                          addr: slot_of(r_oldest, t_cnt'(r_cursor)), wr_data: word_in};

        // Commit or rebase on an empty history behaves as a reset.
        if (op == OP_RESET
            || ((op == OP_REBASE || op == OP_COMMIT) && r_count == '0)) begin
            n_oldest      = '0;
            n_count       = t_cnt'(1);
            n_cursor      = '0;
            n_last_weight = 1'b0;
            n_last_slot   = '1;
            n_last_time   = '0;
            mem_req.wr_en = 1'b1;
            mem_req.addr  = '0;
        end else begin
            unique case (op)
                OP_REBASE: begin
                    mem_req.wr_en = 1'b1;
                end
                OP_COMMIT: begin
                    if (coalesce) begin
                        mem_req.wr_en = 1'b1;
                        n_last_time   = i_in.time_ms;
                    end else begin
                        // Drop the redo tail; a full store evicts its oldest entry.
                        if (append_idx == t_cnt'(HISTORY_DEPTH)) begin
                            n_oldest   = slot_of(r_oldest, t_cnt'(1));
                            append_idx = t_cnt'(HISTORY_DEPTH - 1);
                        end
                        mem_req.wr_en = 1'b1;
                        mem_req.addr  = slot_of(n_oldest, append_idx);
                        n_count       = append_idx + t_cnt'(1);
                        n_cursor      = ADDR_W'(append_idx);
                        n_last_weight = i_in.is_weight_edit;
                        n_last_slot   = i_in.edit_slot;
                        n_last_time   = i_in.time_ms;
                    end
                end
                OP_UNDO: begin
                    if (r_cursor != '0 && r_count != '0) begin
                        n_cursor      = r_cursor - t_addr'(1);
                        n_last_weight = 1'b0;
                        n_last_slot   = '1;
                        restore       = 1'b1;
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = slot_of(r_oldest, t_cnt'(n_cursor));
                    end else begin
                        status = 1'b1;
                    end
                end
                OP_REDO: begin
                    if (append_idx < r_count) begin
                        n_cursor      = ADDR_W'(append_idx);
                        n_last_weight = 1'b0;
                        n_last_slot   = '1;
                        restore       = 1'b1;
                        mem_req.rd_en = 1'b1;
                        mem_req.addr  = slot_of(r_oldest, append_idx);
                    end else begin
                        status = 1'b1;
                    end
                end
                default: begin
                    // Unused opcodes leave the history alone.
                end
            endcase
        end

        if (!accept) begin
            mem_req.wr_en = 1'b0;
            mem_req.rd_en = 1'b0;
        end
    end

    urh_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest      <= '0;
            r_count       <= '0;
            r_cursor      <= '0;
            r_last_weight <= 1'b0;
            r_last_slot   <= '1;
            r_last_time   <= '0;
            r_window      <= WINDOW_RESET;
            r_s_valid     <= 1'b0;
            r_o_valid     <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (accept) begin
                r_oldest      <= n_oldest;
                r_count       <= n_count;
                r_cursor      <= n_cursor;
                r_last_weight <= n_last_weight;
                r_last_slot   <= n_last_slot;
                r_last_time   <= n_last_time;
            end
            if (in_ready) begin
                r_s_valid <= i_in.valid;
            end
            if (s_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload of both result stages; the flags describe the state after the word.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s_status  <= status;
            r_s_restore <= restore;
            r_s_undo    <= (n_count != '0) && (n_cursor != '0);
            r_s_redo    <= (t_cnt'(n_cursor) + t_cnt'(1)) < n_count;
            r_s_count   <= n_count;
        end
        if (s_move) begin
            r_o_status <= r_s_status;
            r_o_word   <= r_s_restore ? SNAP_W'(rd_data) : '0;
            r_o_undo   <= r_s_undo;
            r_o_redo   <= r_s_redo;
            r_o_count  <= HELD_W'(r_s_count);
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.status        = r_o_status;
    assign o_out.restored_word = r_o_word;
    assign o_out.undo_possible = r_o_undo;
    assign o_out.redo_possible = r_o_redo;
    assign o_out.entries_held  = r_o_count;

    // The history never holds more entries than the store has places.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(HISTORY_DEPTH))
        else $error("entry count exceeds the store depth");

    // The cursor always points at a held entry, or at zero when empty.
    a_cursor_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) ? (r_cursor == '0) : (t_cnt'(r_cursor) < r_count))
        else $error("cursor outside the held entries");

    // A successful undo moves the cursor back by exactly one.
    a_undo_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && op == OP_UNDO && r_cursor != '0 && r_count != '0)
        |=> (r_cursor == $past(r_cursor) - t_addr'(1)))
        else $error("undo did not step the cursor back by one");

    // Input stalls only when both result stages are occupied.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_ready |-> (r_s_valid && r_o_valid && !o_out.ready))
        else $error("input stalled with room in the result stages");

    // Store access is only made for an accepted word, and never two at once.
    a_one_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (mem_req.wr_en || mem_req.rd_en) |-> (accept && !(mem_req.wr_en && mem_req.rd_en)))
        else $error("illegal history store access");

endmodule

[src/urh_store.sv]
// Single-port history store: one write or one registered read per cycle.
module urh_store import urh_pkg::*; (
    input  logic     i_clk,
    input  t_mem_req i_req,
    output t_word    o_rd_data
);

    t_word mem [HISTORY_DEPTH];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
